[src/ciau_pkg.sv]
// ----------------------------------------------------------------------------
// ciau_pkg : shared types for the checked integer ALU
// Operation and status codes, controller states and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ciau_pkg;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_NEG = 3'd4,
      OP_ABS = 3'd5,
      OP_POW = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_OVF     = 3'd1,
      ST_UNF     = 3'd2,
      ST_DIV0    = 3'd3,
      ST_INEXACT = 3'd4,
      ST_NOTINT  = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_MUL,
      S_MEND,
      S_DIV,
      S_DEND,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load_in;     // capture the accepted item
      logic load_quick;  // commit the quick-path result
      logic start_iter;  // load the shift-add / shift-subtract unit
      logic mul_step;
      logic div_step;
      logic mul_end;     // classify product, maybe restart for power
      logic div_end;
      logic load_out;    // move the finished result to the output register
   } cmd_type;

   typedef struct packed {
      logic need_mul;
      logic need_div;
      logic cnt_last;
      logic pow_more;
   } dp_stat_type;

endpackage

[src/ciau_ctrl.sv]
// ----------------------------------------------------------------------------
// ciau_ctrl : sequencing for the checked integer ALU
// Walks one item through decode, the iterative unit and the output register.
// ----------------------------------------------------------------------------
module ciau_ctrl import ciau_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  dp_stat_type stat,
   output cmd_type     cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (stat.need_mul)      state_in = S_MUL;
            else if (stat.need_div) state_in = S_DIV;
            else                    state_in = S_FINISH;
         end
         S_MUL: begin
            if (stat.cnt_last) state_in = S_MEND;
         end
         S_MEND: begin
            state_in = stat.pow_more ? S_MUL : S_FINISH;
         end
         S_DIV: begin
            if (stat.cnt_last) state_in = S_DEND;
         end
         S_DEND: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall   = 1'b0;
            cmd.load_in = req_valid;
         end
         S_DECODE: begin
            cmd.start_iter = stat.need_mul | stat.need_div;
            cmd.load_quick = !(stat.need_mul | stat.need_div);
         end
         S_MUL:    cmd.mul_step = 1'b1;
         S_MEND:   cmd.mul_end  = 1'b1;
         S_DIV:    cmd.div_step = 1'b1;
         S_DEND:   cmd.div_end  = 1'b1;
         S_FINISH: cmd.load_out = !rsp_valid_ff || !rsp_stall;
         default:  cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.load_out)               rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[src/ciau_dpath.sv]
// ----------------------------------------------------------------------------
// ciau_dpath : operand registers, quick checks and iterative mul/div unit
// One shift-add multiplier and one restoring divider share the same
// registers and counter; a result bit per cycle.
// ----------------------------------------------------------------------------
module ciau_dpath import ciau_pkg::*; #(
   parameter int DATA_WIDTH = 64
) (
   input  logic               clock,
   input  cmd_type            cmd,
   output dp_stat_type        stat,
   input  logic [2:0]         req_func,
   input  logic signed [63:0] req_operand_a,
   input  logic signed [63:0] req_operand_b,
   input  logic               req_a_is_two_pow_63,
   output logic signed [63:0] rsp_result,
   output logic [2:0]         rsp_status
);

   localparam int W  = DATA_WIDTH;
   localparam int CW = $clog2(DATA_WIDTH);
   localparam logic [W-1:0]  MIN_V  = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0]  ONES_V = {W{1'b1}};
   localparam logic [W-1:0]  ONE_V  = W'(1);
   localparam logic [CW-1:0] LAST_C = CW'(W - 1);

   op_type        op_ff;
   logic [W-1:0]  a_ff, b_ff;
   logic          big_ff;
   logic [W-1:0]  mcand_ff, mcand_in;
   logic [W-1:0]  hi_ff, hi_in;
   logic [W-1:0]  lo_ff, lo_in;
   logic          sign_ff, sign_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  exp_ff, exp_in;
   logic signed [W-1:0] fin_res_ff, fin_res_in;
   status_type    fin_st_ff, fin_st_in;
   logic signed [W-1:0] out_res_ff;
   status_type    out_st_ff;

   logic          a_neg, b_neg, a_min;
   logic [W-1:0]  a_mag, b_mag;
   logic [W:0]    sum_w, dif_w;
   logic [W-1:0]  q_res;
   status_type    q_st;
   logic          need_mul, need_div;

   logic [W:0]    m_t, r_sh, d_t;
   logic          fits;
   logic          p_big, p_is_min, p_out, pow_more;
   logic [W-1:0]  s_val;

   assign a_neg = a_ff[W-1];
   assign b_neg = b_ff[W-1];
   assign a_min = a_ff == MIN_V;
   assign a_mag = a_neg ? -a_ff : a_ff;
   assign b_mag = b_neg ? -b_ff : b_ff;
   assign sum_w = {a_ff[W-1], a_ff} + {b_ff[W-1], b_ff};
   assign dif_w = {a_ff[W-1], a_ff} - {b_ff[W-1], b_ff};

   // combinational outcomes; mul, div and long power go to the iterative unit
   always_comb begin
      q_res    = '0;
      q_st     = ST_OK;
      need_mul = 1'b0;
      need_div = 1'b0;
      if (big_ff) begin
         if (op_ff == OP_NEG)      q_res = MIN_V;
         else if (op_ff == OP_ABS) q_st  = ST_OVF;
         else                      q_st  = ST_NOTINT;
      end else begin
         case (op_ff)
            OP_ADD: begin
               if (sum_w[W] != sum_w[W-1]) q_st = sum_w[W] ? ST_UNF : ST_OVF;
               else                        q_res = sum_w[W-1:0];
            end
            OP_SUB: begin
               // most negative subtrahend with a non-negative minuend is labelled underflow
               if (b_ff == MIN_V && !a_neg)     q_st = ST_UNF;
               else if (dif_w[W] != dif_w[W-1]) q_st = dif_w[W] ? ST_UNF : ST_OVF;
               else                             q_res = dif_w[W-1:0];
            end
            OP_MUL: need_mul = 1'b1;
            OP_DIV: begin
               if (b_ff == '0)                  q_st = ST_DIV0;
               else if (a_min && b_ff == ONES_V) q_st = ST_OVF;
               else                             need_div = 1'b1;
            end
            OP_NEG, OP_ABS: begin
               if (a_min) q_st = ST_OVF;
               else       q_res = (op_ff == OP_ABS) ? a_mag : -a_ff;
            end
            OP_POW: begin
               if (b_neg)                           q_st  = ST_NOTINT;
               else if (b_ff == '0 || a_ff == ONE_V) q_res = ONE_V;
               else if (a_ff == '0)                 q_res = '0;
               else if (a_ff == ONES_V)             q_res = b_ff[0] ? ONES_V : ONE_V;
               else                                 need_mul = 1'b1;
            end
            default: q_st = ST_NOTINT;
         endcase
      end
   end

   // shift-add step: {hi,lo} accumulates, lo holds the remaining multiplier bits
   assign m_t = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);
   // restoring divide step: hi is the partial remainder, lo shifts dividend out
   assign r_sh = {hi_ff, lo_ff[W-1]};
   assign d_t  = r_sh - {1'b0, mcand_ff};
   assign fits = !d_t[W];

   // product magnitude is {hi,lo}; negative side may reach the minimum value
   assign p_big    = (hi_ff != '0) || lo_ff[W-1];
   assign p_is_min = (hi_ff == '0) && (lo_ff == MIN_V);
   assign p_out    = sign_ff ? (p_big && !p_is_min) : p_big;
   assign s_val    = sign_ff ? -lo_ff : lo_ff;
   assign pow_more = (op_ff == OP_POW) && !p_out && (exp_ff != ONE_V);

   always_comb begin
      mcand_in   = mcand_ff;
      hi_in      = hi_ff;
      lo_in      = lo_ff;
      sign_in    = sign_ff;
      cnt_in     = cnt_ff;
      exp_in     = exp_ff;
      fin_res_in = fin_res_ff;
      fin_st_in  = fin_st_ff;
      if (cmd.load_quick) begin
         fin_res_in = q_res;
         fin_st_in  = q_st;
      end
      if (cmd.start_iter) begin
         hi_in    = '0;
         cnt_in   = '0;
         exp_in   = b_ff;
         mcand_in = (op_ff == OP_DIV) ? b_mag : a_mag;
         if (op_ff == OP_POW) begin
            lo_in   = ONE_V;
            sign_in = a_neg;
         end else begin
            lo_in   = (op_ff == OP_DIV) ? a_mag : b_mag;
            sign_in = a_neg ^ b_neg;
         end
      end
      if (cmd.mul_step) begin
         hi_in  = m_t[W:1];
         lo_in  = {m_t[0], lo_ff[W-1:1]};
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.div_step) begin
         hi_in  = fits ? d_t[W-1:0] : r_sh[W-1:0];
         lo_in  = {lo_ff[W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.mul_end) begin
         if (p_out) begin
            fin_res_in = '0;
            fin_st_in  = sign_ff ? ST_UNF : ST_OVF;
         end else begin
            fin_res_in = s_val;
            fin_st_in  = ST_OK;
         end
         if (pow_more) begin
            // next power: multiplier is |acc| already in lo
            hi_in   = '0;
            cnt_in  = '0;
            sign_in = sign_ff ^ a_neg;
            exp_in  = exp_ff - 1'b1;
         end
      end
      if (cmd.div_end) begin
         fin_res_in = s_val;
         fin_st_in  = (hi_ff != '0) ? ST_INEXACT : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         op_ff  <= op_type'(req_func);
         a_ff   <= req_operand_a[W-1:0];
         b_ff   <= req_operand_b[W-1:0];
         big_ff <= req_a_is_two_pow_63;
      end
      mcand_ff   <= mcand_in;
      hi_ff      <= hi_in;
      lo_ff      <= lo_in;
      sign_ff    <= sign_in;
      cnt_ff     <= cnt_in;
      exp_ff     <= exp_in;
      fin_res_ff <= fin_res_in;
      fin_st_ff  <= fin_st_in;
      if (cmd.load_out) begin
         out_res_ff <= fin_res_ff;
         out_st_ff  <= fin_st_ff;
      end
   end

   assign stat.need_mul = need_mul;
   assign stat.need_div = need_div;
   assign stat.cnt_last = cnt_ff == LAST_C;
   assign stat.pow_more = pow_more;

   assign rsp_result = 64'(out_res_ff);
   assign rsp_status = out_st_ff;

endmodule

[src/checked_integer_alu_core.sv]
// ----------------------------------------------------------------------------
// checked_integer_alu_core : overflow-checked signed integer ALU
// Add, subtract, multiply, divide, negate, abs and power with status.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: func, two signed operands and the 2^63 flag.
//   It is taken when req_valid is high and req_stall low. Operands use
//   their low DATA_WIDTH bits; rsp_result is sign-extended to 64 bits.
//   rsp_* returns one item per request: result and status, taken when
//   rsp_valid is high and rsp_stall low; an error status gives result 0.
// Steps (W = DATA_WIDTH), from acceptance:
//   add, sub, negate, abs, trivial power and error cases: decode, then
//   finish, which moves the result to the output register. Multiply and
//   divide: decode, W one-bit steps of the shift-add / shift-subtract
//   unit, end step, finish. Power with a base of magnitude two or more:
//   one multiply per exponent step, ending when the exponent is used up
//   or at the first range error (at most W multiplies). One item is in
//   the unit at a time.
// Stall: a finished result waits in the output register; the next item
//   is accepted and worked on meanwhile, and holds at the end until the
//   register is free.
// Reset: synchronous; controller goes idle and the output is emptied.
// ----------------------------------------------------------------------------
module checked_integer_alu_core import ciau_pkg::*; #(
   parameter int DATA_WIDTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_func,
   input  logic signed [63:0] req_operand_a,
   input  logic signed [63:0] req_operand_b,
   input  logic               req_a_is_two_pow_63,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [63:0] rsp_result,
   output logic [2:0]         rsp_status
);

   cmd_type     cmd;
   dp_stat_type stat;

   // sequencing: decode, iterate, hand to output register
   ciau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // operands, range checks and the shared bit-serial mul/div unit
   ciau_dpath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock               (clock),
      .cmd                 (cmd),
      .stat                (stat),
      .req_func            (req_func),
      .req_operand_a       (req_operand_a),
      .req_operand_b       (req_operand_b),
      .req_a_is_two_pow_63 (req_a_is_two_pow_63),
      .rsp_result          (rsp_result),
      .rsp_status          (rsp_status)
   );

`ifndef SYNTHESIS
   // one item at a time: after an accept the input side is closed
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted while an item is in progress");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= 3'(ST_NOTINT)))
      else $error("undefined status code");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != 3'(ST_OK) && rsp_status != 3'(ST_INEXACT))
      |-> (rsp_result == '0))
      else $error("nonzero result with error status");
`endif

endmodule

[tb/sv/checked_integer_alu_core_tb.sv]
// ----------------------------------------------------------------------------
// checked_integer_alu_core_tb : self-checking bench for the checked ALU
// A directed table (extremes, every operation, the error classes) runs
// first, then random items. Each accepted item is run through a local
// model of the checked arithmetic; results are matched in order.
// ----------------------------------------------------------------------------
module checked_integer_alu_core_tb import ciau_pkg::*; ();

   localparam longint LMAX = 64'sh7fff_ffff_ffff_ffff;
   localparam longint LMIN = 64'sh8000_0000_0000_0000;
   localparam int N_RANDOM = 600;
   localparam int CYCLE_LIMIT = 20_000_000;
   localparam logic [2:0] FUNC_UNUSED = 3'd7;

   // directed rows; chk=1 means exp_res/exp_st were typed in by hand
   typedef struct {
      logic [2:0]  func;
      longint      a;
      longint      b;
      logic        big;
      bit          chk;
      longint      exp_res;
      logic [2:0]  exp_st;
   } vec_type;

   typedef struct {
      longint     res;
      logic [2:0] st;
   } alu_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_func = '0;
   logic signed [63:0] req_operand_a = '0;
   logic signed [63:0] req_operand_b = '0;
   logic req_a_is_two_pow_63 = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [63:0] rsp_result;
   logic [2:0] rsp_status;

   alu_out_type pending_rsp[$];
   int errors = 0;
   int cycles = 0;
   int n_sent = 0;
   int n_recv = 0;
   int n_err_status = 0;
   int stall_left = 0;
   bit stall_enable = 1'b0;

   always #5 clock = ~clock;

   checked_integer_alu_core dut (.*);

   // ---------------- predictor ----------------
   function automatic logic [2:0] mul_checked(input longint a, input longint b,
                                               output longint r);
      logic [63:0] ua, ub;
      ua = a; ub = b;
      r = 0;
      if (a > 1) begin
         if (b > 1) begin
            if (ua > 64'(LMAX) / ub) return ST_OVF;
         end else if (b == LMIN) begin
            return ST_UNF;
         end else if (b < -1) begin
            if (ua > (64'(LMAX) + 64'd1) / (-ub)) return ST_UNF;
         end
      end else if (a == -1) begin
         if (b == LMIN) return ST_OVF;
      end else if (a == LMIN) begin
         if (b > 1) return ST_UNF;
         if (b < 0) return ST_OVF;
      end else if (a < -1) begin
         if (b > 1) begin
            if (-ua > (64'(LMAX) + 64'd1) / ub) return ST_UNF;
         end else if (b == LMIN) begin
            return ST_OVF;
         end else if (b < -1) begin
            if (-ua > 64'(LMAX) / (-ub)) return ST_OVF;
         end
      end
      r = a * b;
      return ST_OK;
   endfunction

   function automatic alu_out_type predict_alu(input logic [2:0] func, input longint a,
                                               input longint b, input logic big);
      alu_out_type o;
      longint acc, e;
      o.res = 0;
      o.st = ST_OK;
      if (big) begin
         if (func == OP_NEG) o.res = LMIN;
         else if (func == OP_ABS) o.st = ST_OVF;
         else o.st = ST_NOTINT;
      end else begin
         case (func)
            OP_ADD: begin
               if (b > 0 && a > LMAX - b) o.st = ST_OVF;
               else if (b == LMIN && a < 0) o.st = ST_UNF;
               else if (b < 0 && b != LMIN && a < LMIN - b) o.st = ST_UNF;
               else o.res = a + b;
            end
            OP_SUB: begin
               // most negative subtrahend with a >= 0 is labelled underflow
               if (b > 0 && a < LMIN + b) o.st = ST_UNF;
               else if (b == LMIN && a >= 0) o.st = ST_UNF;
               else if (b < 0 && b != LMIN && a > LMAX + b) o.st = ST_OVF;
               else o.res = a - b;
            end
            OP_MUL: o.st = mul_checked(a, b, o.res);
            OP_DIV: begin
               if (b == 0) o.st = ST_DIV0;
               else if (a == LMIN && b == -1) o.st = ST_OVF;
               else begin
                  o.res = a / b;
                  if (a % b != 0) o.st = ST_INEXACT;
               end
            end
            OP_NEG, OP_ABS: begin
               if (a == LMIN) o.st = ST_OVF;
               else o.res = (func == OP_ABS && a >= 0) ? a : -a;
            end
            OP_POW: begin
               if (b < 0) o.st = ST_NOTINT;
               else if (b == 0 || a == 1) o.res = 1;
               else if (a == 0) o.res = 0;
               else if (a == -1) o.res = b[0] ? -1 : 1;
               else begin
                  acc = 1;
                  e = b;
                  while (e > 0 && o.st == ST_OK) begin
                     o.st = mul_checked(acc, a, acc);
                     e--;
                  end
                  o.res = acc;
               end
            end
            default: o.st = ST_NOTINT;
         endcase
      end
      if (o.st != ST_OK && o.st != ST_INEXACT) o.res = 0;
      return o;
   endfunction

   // ---------------- driver ----------------
   function automatic int gap_len();
      int n;
      n = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 80);
      return n;
   endfunction

   task automatic send_item(input vec_type v);
      alu_out_type p;
      int n;
      req_valid <= 1'b1;
      req_func <= v.func;
      req_operand_a <= v.a;
      req_operand_b <= v.b;
      req_a_is_two_pow_63 <= v.big;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // item taken at this edge
      p = predict_alu(v.func, v.a, v.b, v.big);
      if (v.chk && (p.res !== v.exp_res || p.st !== v.exp_st))
         $display("%0t note: table row disagrees with predictor", $time);
      if (v.chk) begin
         p.res = v.exp_res;
         p.st = v.exp_st;
      end
      pending_rsp = {pending_rsp, p};
      n_sent++;
      if ($urandom_range(0, 3) == 0) begin
         n = gap_len();
         if (n > 0) begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
   endtask

   function automatic longint rand_operand(input bit small_only);
      longint v;
      case (small_only ? 0 : $urandom_range(0, 7))
         0: v = longint'($urandom_range(0, 20)) - 10;
         1: v = LMAX - $urandom_range(0, 3);
         2: v = LMIN + $urandom_range(0, 3);
         3: v = longint'($signed($urandom())) ;
         4: v = longint'($urandom_range(0, 1)) ? 64'sd1 << $urandom_range(0, 62)
                                                : -(64'sd1 << $urandom_range(0, 62));
         default: v = {$urandom(), $urandom()};
      endcase
      return v;
   endfunction

   // ---------------- sink and checker ----------------
   always @(posedge clock) begin
      alu_out_type e;
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t timeout, %0d results outstanding", $time, pending_rsp.size());
         $display("** checked_integer_alu_core: FAILED **");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected item: result %0d status %0d", $time,
                     rsp_result, rsp_status);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            n_recv++;
            if (e.st != ST_OK) n_err_status++;
            if (rsp_result !== e.res) begin
               $display("%0t result mismatch: expected %0d actual %0d", $time,
                        e.res, rsp_result);
               errors++;
            end
            if (rsp_status !== e.st) begin
               $display("%0t status mismatch: expected %0d actual %0d", $time,
                        e.st, rsp_status);
               errors++;
            end
         end
      end
      // receiver back-pressure: mostly short, sometimes long
      if (!stall_enable) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) < 3) begin
         rsp_stall <= 1'b1;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------- stimulus ----------------
   initial begin
      vec_type tbl[$];
      vec_type v;
      int drain;
      tbl = '{
         '{OP_ADD, 0, 0, 0, 1, 0, ST_OK},
         '{OP_ADD, LMAX, 1, 0, 1, 0, ST_OVF},
         '{OP_ADD, -1, LMIN, 0, 1, 0, ST_UNF},
         '{OP_ADD, LMIN, -1, 0, 1, 0, ST_UNF},
         '{OP_ADD, LMAX, LMIN, 0, 1, -1, ST_OK},
         '{OP_SUB, LMIN, 1, 0, 1, 0, ST_UNF},
         '{OP_SUB, 0, LMIN, 0, 1, 0, ST_UNF},
         '{OP_SUB, -1, LMIN, 0, 1, LMAX, ST_OK},
         '{OP_SUB, LMAX, -1, 0, 1, 0, ST_OVF},
         '{OP_MUL, LMAX, 2, 0, 1, 0, ST_OVF},
         '{OP_MUL, LMIN, -1, 0, 1, 0, ST_OVF},
         '{OP_MUL, LMIN, 2, 0, 1, 0, ST_UNF},
         '{OP_MUL, -3, 7, 0, 0, 0, ST_OK},
         '{OP_MUL, LMIN, 1, 0, 1, LMIN, ST_OK},
         '{OP_DIV, 5, 0, 0, 1, 0, ST_DIV0},
         '{OP_DIV, LMIN, -1, 0, 1, 0, ST_OVF},
         '{OP_DIV, -7, 2, 0, 1, -3, ST_INEXACT},
         '{OP_NEG, LMIN, 0, 0, 1, 0, ST_OVF},
         '{OP_ABS, -5, LMAX, 0, 1, 5, ST_OK},
         '{OP_NEG, 0, 0, 1, 1, LMIN, ST_OK},
         '{OP_ABS, 0, 0, 1, 1, 0, ST_OVF},
         '{OP_ADD, 1, 1, 1, 1, 0, ST_NOTINT},
         '{OP_POW, 3, -1, 0, 1, 0, ST_NOTINT},
         '{OP_POW, -1, 63, 0, 1, -1, ST_OK},
         '{OP_POW, 2, 63, 0, 1, 0, ST_OVF},
         '{OP_POW, -2, 63, 0, 1, LMIN, ST_OK},
         '{FUNC_UNUSED, 0, 0, 0, 1, 0, ST_NOTINT}
      };
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (tbl[i]) send_item(tbl[i]);
      stall_enable = 1'b1;
      for (int i = 0; i < N_RANDOM; i++) begin
         // one hold-off midway: wait for the block to drain completely
         if (i == N_RANDOM / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_rsp.size() != 0) @(posedge clock);
         end
         v.func = ($urandom_range(0, 49) == 0) ? FUNC_UNUSED : 3'($urandom_range(0, 6));
         v.a = rand_operand(1'b0);
         v.b = rand_operand(1'b0);
         if (v.func == OP_POW && $urandom_range(0, 3) != 0) begin
            v.a = rand_operand(1'b1);
            v.b = longint'($urandom_range(0, 70));
         end
         v.big = ($urandom_range(0, 19) == 0);
         v.chk = 0;
         send_item(v);
      end
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      stall_enable = 1'b0;
      // let any late spurious item show up
      for (drain = 0; drain < 200; drain++) @(posedge clock);
      $display("Covered %0d items (%0d received, %0d with error or inexact status),",
               n_sent, n_recv, n_err_status);
      $display("all seven operations, literal flag, and random stalls on both sides.");
      if (errors == 0) begin
         $display("** checked_integer_alu_core: PASSED **");
      end else begin
         $display("** checked_integer_alu_core: FAILED **");
      end
      $finish;
   end
endmodule
